// ===== hw/rtl/zrle_pkg.sv =====
// Shared types and constants for the zero run-length scan decoder.
// Holds field widths, status codes, queue command layout and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package zrle_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned LANES    = 8;
  localparam int unsigned WORD_W   = PIXEL_W * LANES;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SUM_W    = 17;

  // Parameter defaults
  localparam int unsigned IMAGE_ROWS_DEF     = 32;
  localparam int unsigned IMAGE_COLS_DEF     = 16;
  localparam int unsigned MAX_COMPRESSED_DEF = 512;

  // Command queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // Value constants
  localparam logic [PIXEL_W-1:0] SAMPLE_OFFSET = 8'd128;
  localparam logic [PIXEL_W-1:0] PEAK_MARK     = 8'd255;
  localparam logic [SUM_W-1:0]   SUM_MAX       = 17'h1FFFF;

  // End-of-scan status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_COMP_LONG = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_DEC_LONG  = 3'd3,
    STATUS_SHORT     = 3'd4
  } status_e;

  // Command kinds handed from front to back
  typedef enum logic {
    CMD_PIXEL    = 1'b0,
    CMD_ZERO_RUN = 1'b1
  } cmd_e;

  // One queued command: a single pixel or a run of zeros
  typedef struct packed {
    cmd_e                 kind;
    logic [PIXEL_W-1:0]   value;
    logic                 last;
    logic                 comp_ovf;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_TAKE,
    BK_RUN,
    BK_DECIDE,
    BK_READ,
    BK_LOAD
  } back_state_e;

endpackage

// ===== hw/rtl/zrle_scan_if.sv =====
// Input channel carrying compressed scan bytes.
// Depends on zrle_pkg for field widths.
`timescale 1ns / 1ps

interface zrle_scan_if;
  logic                                valid;
  logic                                ready;
  logic signed [zrle_pkg::SAMPLE_W-1:0] sample;
  logic                                end_of_scan;

  modport source (output valid, output sample, output end_of_scan, input ready);
  modport sink   (input valid, input sample, input end_of_scan, output ready);
endinterface

// ===== hw/rtl/zrle_image_if.sv =====
// Output channel carrying image words and scan status.
// Depends on zrle_pkg for field widths.
`timescale 1ns / 1ps

interface zrle_image_if;
  logic                          valid;
  logic                          ready;
  logic [zrle_pkg::WORD_W-1:0]   pixel_word;
  logic [zrle_pkg::INDEX_W-1:0]  word_index;
  logic                          last_word;
  logic [zrle_pkg::STATUS_W-1:0] status;
  logic [zrle_pkg::SUM_W-1:0]    total_sum;
  logic [zrle_pkg::PIXEL_W-1:0]  peak_value;

  modport source (output valid, output pixel_word, output word_index, output last_word,
                  output status, output total_sum, output peak_value, input ready);
  modport sink   (input valid, input pixel_word, input word_index, input last_word,
                  input status, input total_sum, input peak_value, output ready);
endinterface

// ===== hw/rtl/zrle_front.sv =====
// Front end: accepts scan bytes, tracks run markers and compressed length,
// and turns each byte, except a non-final run marker, into a pixel or zero-run command. Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_front #(
  parameter int unsigned MAX_COMPRESSED = zrle_pkg::MAX_COMPRESSED_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  zrle_scan_if.sink          scan_i,
  input  logic               full_i,
  output logic               push_o,
  output zrle_pkg::cmd_t     cmd_o
);

  localparam int unsigned COMP_W = $clog2(MAX_COMPRESSED + 1);
  localparam logic [COMP_W-1:0] MAX_C = COMP_W'(MAX_COMPRESSED);

  logic                          pending_q;
  logic [COMP_W-1:0]             comp_cnt_q;
  logic                          comp_ovf_q;
  logic                          comp_ovf_d;
  logic                          accept;
  logic [zrle_pkg::PIXEL_W-1:0]  u;

  assign scan_i.ready = !full_i;
  assign accept       = scan_i.valid && scan_i.ready;

  // Offset the byte and classify it
  always_comb begin
    u          = $unsigned(scan_i.sample) + zrle_pkg::SAMPLE_OFFSET;
    comp_ovf_d = comp_ovf_q | (comp_cnt_q == MAX_C);
    cmd_o.kind     = pending_q ? zrle_pkg::CMD_ZERO_RUN : zrle_pkg::CMD_PIXEL;
    cmd_o.value    = u;
    cmd_o.last     = scan_i.end_of_scan;
    cmd_o.comp_ovf = comp_ovf_d;
    // a marker that is not the final byte only arms the run
    push_o = accept && (pending_q || (u != '0) || scan_i.end_of_scan);
  end

  // Track marker and compressed length; clear at end of scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      comp_cnt_q <= '0;
      comp_ovf_q <= 1'b0;
    end else if (accept) begin
      if (scan_i.end_of_scan) begin
        pending_q  <= 1'b0;
        comp_cnt_q <= '0;
        comp_ovf_q <= 1'b0;
      end else begin
        pending_q  <= !pending_q && (u == '0);
        comp_ovf_q <= comp_ovf_d;
        if (comp_cnt_q < MAX_C) begin
          comp_cnt_q <= comp_cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/zrle_queue.sv =====
// Short command queue between front and back end.
// Depends on zrle_pkg for the command type and depth.
`timescale 1ns / 1ps

module zrle_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  zrle_pkg::cmd_t  cmd_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output zrle_pkg::cmd_t  cmd_o
);

  localparam int unsigned PTR_W = $clog2(zrle_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(zrle_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(zrle_pkg::QUEUE_DEPTH);

  zrle_pkg::cmd_t    slot_q [zrle_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == DEPTH_C);
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/zrle_back.sv =====
// Back end: expands commands into the pixel store, keeps peak and sum,
// checks the scan at its end and emits the image or a status word. Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_back #(
  parameter int unsigned IMAGE_ROWS = zrle_pkg::IMAGE_ROWS_DEF,
  parameter int unsigned IMAGE_COLS = zrle_pkg::IMAGE_COLS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  zrle_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  zrle_image_if.source    image_o
);

  localparam int unsigned PIXELS  = IMAGE_ROWS * IMAGE_COLS;
  localparam int unsigned WORDS   = (PIXELS + zrle_pkg::LANES - 1) / zrle_pkg::LANES;
  localparam int unsigned CNT_W   = $clog2(PIXELS + 1);
  localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned LANE_W  = $clog2(zrle_pkg::LANES);
  localparam int unsigned TAIL    = PIXELS - zrle_pkg::LANES * (WORDS - 1);
  localparam int unsigned PW      = zrle_pkg::PIXEL_W;
  localparam int unsigned SW      = zrle_pkg::SUM_W;
  localparam logic [CNT_W-1:0]   PIXELS_C = CNT_W'(PIXELS);
  localparam logic [WADDR_W-1:0] LAST_W_C = WADDR_W'(WORDS - 1);

  zrle_pkg::back_state_e state_q, state_d;

  // Scan state
  logic [CNT_W-1:0]        dec_cnt_q;
  logic                    dec_ovf_q;
  logic [PW-1:0]           peak_q;
  logic [SW-1:0]           sum_q;
  logic                    comp_ovf_q;
  logic                    last_q;
  logic [PW-1:0]           run_q;
  logic [WADDR_W-1:0]      rd_idx_q;
  logic [zrle_pkg::WORD_W-1:0] rd_data_q;
  logic [zrle_pkg::WORD_W-1:0] mem_q [WORDS];

  // Sequencer controls
  logic           pix_we;
  logic [PW-1:0]  pix_val;
  logic           run_load;
  logic           run_dec;
  logic           rd_en;
  logic           rd_clr;
  logic           rd_inc;
  logic           load_status;
  logic           load_word;
  logic           clear_scan;

  // Datapath helpers
  logic                     out_free;
  logic                     rd_last;
  logic [SW:0]              sum_add;
  logic [SW-1:0]            sum_d;
  zrle_pkg::status_e        status_c;
  logic [zrle_pkg::WORD_W-1:0] word_c;
  logic [PW-1:0]            lane_px;

  assign out_free = !image_o.valid || image_o.ready;
  assign rd_last  = (rd_idx_q == LAST_W_C);

  // Classify the finished scan
  always_comb begin
    if (comp_ovf_q) begin
      status_c = zrle_pkg::STATUS_COMP_LONG;
    end else if ((dec_cnt_q == '0) && !dec_ovf_q) begin
      status_c = zrle_pkg::STATUS_EMPTY;
    end else if (dec_ovf_q) begin
      status_c = zrle_pkg::STATUS_DEC_LONG;
    end else if (dec_cnt_q < PIXELS_C) begin
      status_c = zrle_pkg::STATUS_SHORT;
    end else begin
      status_c = zrle_pkg::STATUS_OK;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      zrle_pkg::BK_TAKE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == zrle_pkg::CMD_ZERO_RUN && cmd_i.value != '0) begin
            state_d = zrle_pkg::BK_RUN;
          end else if (cmd_i.last) begin
            state_d = zrle_pkg::BK_DECIDE;
          end
        end
      end
      zrle_pkg::BK_RUN: begin
        if (run_q == PW'(1)) begin
          state_d = last_q ? zrle_pkg::BK_DECIDE : zrle_pkg::BK_TAKE;
        end
      end
      zrle_pkg::BK_DECIDE: begin
        if (status_c == zrle_pkg::STATUS_OK) begin
          state_d = zrle_pkg::BK_READ;
        end else if (out_free) begin
          state_d = zrle_pkg::BK_TAKE;
        end
      end
      zrle_pkg::BK_READ: state_d = zrle_pkg::BK_LOAD;
      zrle_pkg::BK_LOAD: begin
        if (out_free) begin
          state_d = rd_last ? zrle_pkg::BK_TAKE : zrle_pkg::BK_READ;
        end
      end
      default: state_d = zrle_pkg::BK_TAKE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o       = 1'b0;
    pix_we      = 1'b0;
    pix_val     = '0;
    run_load    = 1'b0;
    run_dec     = 1'b0;
    rd_en       = 1'b0;
    rd_clr      = 1'b0;
    rd_inc      = 1'b0;
    load_status = 1'b0;
    load_word   = 1'b0;
    clear_scan  = 1'b0;
    case (state_q)
      zrle_pkg::BK_TAKE: begin
        pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          if (cmd_i.kind == zrle_pkg::CMD_PIXEL) begin
            pix_we  = 1'b1;
            pix_val = cmd_i.value;
          end else begin
            run_load = 1'b1;
          end
        end
      end
      zrle_pkg::BK_RUN: begin
        pix_we  = 1'b1;
        run_dec = 1'b1;
      end
      zrle_pkg::BK_DECIDE: begin
        if (status_c == zrle_pkg::STATUS_OK) begin
          rd_clr = 1'b1;
        end else if (out_free) begin
          load_status = 1'b1;
          clear_scan  = 1'b1;
        end
      end
      zrle_pkg::BK_READ: rd_en = 1'b1;
      zrle_pkg::BK_LOAD: begin
        if (out_free) begin
          load_word  = 1'b1;
          clear_scan = rd_last;
          rd_inc     = !rd_last;
        end
      end
      default: ;
    endcase
  end

  // Saturating sum of decoded values
  always_comb begin
    sum_add = {1'b0, sum_q} + (SW + 1)'(pix_val);
    sum_d   = sum_add[SW] ? zrle_pkg::SUM_MAX : sum_add[SW-1:0];
  end

  // Build one image word: mark peaks, blank lanes past the image
  always_comb begin
    word_c  = '0;
    lane_px = '0;
    for (int b = 0; b < int'(zrle_pkg::LANES); b++) begin
      lane_px = rd_data_q[b*PW +: PW];
      if (lane_px == peak_q) begin
        lane_px = zrle_pkg::PEAK_MARK;
      end
      if (rd_last && (b >= int'(TAIL))) begin
        lane_px = '0;
      end
      word_c[b*PW +: PW] = lane_px;
    end
  end

  // Sequencer register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zrle_pkg::BK_TAKE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan state: counts, peak, sum, run length, read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_cnt_q  <= '0;
      dec_ovf_q  <= 1'b0;
      peak_q     <= '0;
      sum_q      <= '0;
      comp_ovf_q <= 1'b0;
      last_q     <= 1'b0;
      run_q      <= '0;
      rd_idx_q   <= '0;
    end else begin
      if (pop_o) begin
        last_q     <= cmd_i.last;
        comp_ovf_q <= cmd_i.comp_ovf;
      end
      if (run_load) begin
        run_q <= cmd_i.value;
      end else if (run_dec) begin
        run_q <= run_q - 1'b1;
      end
      if (pix_we) begin
        if (dec_cnt_q < PIXELS_C) begin
          dec_cnt_q <= dec_cnt_q + 1'b1;
        end else begin
          dec_ovf_q <= 1'b1;
        end
        if (pix_val > peak_q) begin
          peak_q <= pix_val;
        end
        sum_q <= sum_d;
      end
      if (rd_clr) begin
        rd_idx_q <= '0;
      end else if (rd_inc) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (clear_scan) begin
        dec_cnt_q  <= '0;
        dec_ovf_q  <= 1'b0;
        peak_q     <= '0;
        sum_q      <= '0;
        comp_ovf_q <= 1'b0;
        last_q     <= 1'b0;
      end
    end
  end

  // Pixel store: byte writes, registered word reads
  always_ff @(posedge clk_i) begin
    if (pix_we && (dec_cnt_q < PIXELS_C)) begin
      mem_q[dec_cnt_q[LANE_W +: WADDR_W]][dec_cnt_q[LANE_W-1:0]*PW +: PW] <= pix_val;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_o.valid <= 1'b0;
    end else if (load_status || load_word) begin
      image_o.valid <= 1'b1;
    end else if (image_o.ready) begin
      image_o.valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load_status) begin
      image_o.pixel_word <= '0;
      image_o.word_index <= '0;
      image_o.last_word  <= 1'b1;
      image_o.status     <= status_c;
      image_o.total_sum  <= comp_ovf_q ? '0 : sum_q;
      image_o.peak_value <= comp_ovf_q ? '0 : peak_q;
    end else if (load_word) begin
      image_o.pixel_word <= word_c;
      image_o.word_index <= zrle_pkg::INDEX_W'(rd_idx_q);
      image_o.last_word  <= rd_last;
      image_o.status     <= zrle_pkg::STATUS_OK;
      image_o.total_sum  <= sum_q;
      image_o.peak_value <= peak_q;
    end
  end

endmodule

// ===== hw/rtl/zero_rle_scan_to_image.sv =====
// Top level of the zero run-length scan decoder.
// Depends on zrle_pkg, zrle_scan_if, zrle_image_if, zrle_front, zrle_queue, zrle_back.
`timescale 1ns / 1ps

// Usage:
//   scan_i carries one compressed byte per word (sample, end_of_scan); a word
//   is taken when valid and ready are both high. image_o returns results with
//   the same handshake.
//   The front end takes one byte per cycle into a four-entry command queue and
//   only stalls when that queue is full. The back end writes one decoded pixel
//   per cycle while it has commands and is not busy with the end of a scan: a
//   plain byte gives one pixel, a run marker gives none, and its count is
//   taken and then gives one pixel per zero; the back-end pixel rate sets
//   sustained throughput. At end of scan the back end runs the checks. A
//   failed scan gives one status word; a good scan gives IMAGE_ROWS*IMAGE_COLS/8
//   words, rounded up, each read from the store and then loaded into the
//   output register. Scan bytes keep entering the queue meanwhile.
//   When the receiver stalls, the output register holds its word and the back
//   end waits; the front end keeps accepting until the queue fills.
//   Reset clears all scan state and the queue; the pixel store needs no
//   clearing since only pixels written in the current scan are read.

module zero_rle_scan_to_image #(
  parameter int unsigned IMAGE_ROWS     = zrle_pkg::IMAGE_ROWS_DEF,
  parameter int unsigned IMAGE_COLS     = zrle_pkg::IMAGE_COLS_DEF,
  parameter int unsigned MAX_COMPRESSED = zrle_pkg::MAX_COMPRESSED_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  zrle_scan_if.sink     scan_i,
  zrle_image_if.source  image_o
);

  logic            push;
  logic            full;
  logic            cmd_valid;
  logic            pop;
  zrle_pkg::cmd_t  cmd_in;
  zrle_pkg::cmd_t  cmd_out;

  // Accept and classify bytes
  zrle_front #(
    .MAX_COMPRESSED (MAX_COMPRESSED)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // Decouple front and back
  zrle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_out)
  );

  // Expand, check and emit
  zrle_back #(
    .IMAGE_ROWS (IMAGE_ROWS),
    .IMAGE_COLS (IMAGE_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .image_o     (image_o)
  );

  // Never push a command into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("command pushed into full queue");

  // A failure status is always a single, final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (image_o.valid && (image_o.status != zrle_pkg::STATUS_OK)) |->
      (image_o.last_word && (image_o.word_index == '0) && (image_o.pixel_word == '0)))
    else $error("failure status not a lone final word");

  // An overlong compressed scan reports no sum and no peak
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (image_o.valid && (image_o.status == zrle_pkg::STATUS_COMP_LONG)) |->
      ((image_o.total_sum == '0) && (image_o.peak_value == '0)))
    else $error("overlong scan carries sum or peak");

endmodule

// ===== tb/sv/zero_rle_scan_to_image_tb.sv =====
// Self-checking testbench for the zero run-length scan decoder.
// Drives scan bytes over zrle_scan_if and checks every image word and status word.
// Depends on zrle_pkg, zrle_scan_if, zrle_image_if and zero_rle_scan_to_image.
`timescale 1ns / 1ps

module zero_rle_scan_to_image_tb;
  import zrle_pkg::*;

  localparam int unsigned PIXELS       = IMAGE_ROWS_DEF * IMAGE_COLS_DEF;
  localparam int unsigned WORDS        = (PIXELS + LANES - 1) / LANES;
  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 4 * WORDS + 40;
  localparam int unsigned RAND_BYTES   = 100;
  localparam int unsigned RAND_SCANS   = 10;

  typedef struct packed {
    logic [WORD_W-1:0]   pixel_word;
    logic [INDEX_W-1:0]  word_index;
    logic                last_word;
    status_e             status;
    logic [SUM_W-1:0]    total_sum;
    logic [PIXEL_W-1:0]  peak_value;
  } image_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                eos;
  } scan_byte_t;

  // One directed row; a typed row carries its own failure status word
  typedef struct {
    scan_byte_t          b;
    bit                  typed;
    status_e             status;
    logic [SUM_W-1:0]    sum;
    logic [PIXEL_W-1:0]  peak;
  } stim_row_t;

  typedef enum {
    SCAN_EXACT,
    SCAN_FINAL_MARK,
    SCAN_SHORT,
    SCAN_LONG,
    SCAN_EMPTY,
    SCAN_NOISE,
    SCAN_BROKEN
  } scan_kind_e;

  logic clk_i;
  logic rst_ni;

  zrle_scan_if  scan_if ();
  zrle_image_if image_if ();

  zero_rle_scan_to_image u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan_if),
    .image_o (image_if)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Decoder state of the predictor
  logic [PIXEL_W-1:0] pix_mem [PIXELS];
  int unsigned        dec_cnt;
  int unsigned        comp_cnt;
  int unsigned        run_sum;
  bit                 dec_ovf;
  bit                 comp_ovf;
  bit                 run_pending;
  logic [PIXEL_W-1:0] run_peak;

  image_word_t scan_out_q[$];       // words caused by the latest byte
  image_word_t image_words_due[$];  // words still to arrive, oldest first
  scan_byte_t  scan_bytes[$];       // random scan under construction
  stim_row_t   dir_rows[$];

  int fail_count    = 0;
  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;

  // Sample byte that decodes to value u; the offset is its own inverse mod 256
  function automatic logic [PIXEL_W-1:0] enc(input int unsigned u);
    logic [PIXEL_W-1:0] v;
    v = u[PIXEL_W-1:0];
    return v + SAMPLE_OFFSET;
  endfunction

  function automatic stim_row_t stim(input logic [SAMPLE_W-1:0] sample, input bit eos,
                                     input bit typed = 1'b0, input status_e st = STATUS_OK,
                                     input logic [SUM_W-1:0] sum = '0,
                                     input logic [PIXEL_W-1:0] peak = '0);
    stim_row_t r;
    r.b.sample = sample;
    r.b.eos    = eos;
    r.typed    = typed;
    r.status   = st;
    r.sum      = sum;
    r.peak     = peak;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len(input bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (allow_zero && r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_scan_state();
    dec_cnt     = 0;
    comp_cnt    = 0;
    run_sum     = 0;
    dec_ovf     = 1'b0;
    comp_ovf    = 1'b0;
    run_pending = 1'b0;
    run_peak    = '0;
  endfunction

  // Append one decoded pixel; track peak and saturating sum
  function automatic void store_pixel(input logic [PIXEL_W-1:0] v);
    if (dec_cnt < PIXELS) begin
      pix_mem[dec_cnt] = v;
      dec_cnt++;
    end else begin
      dec_ovf = 1'b1;
    end
    if (v > run_peak) run_peak = v;
    run_sum = run_sum + v;
    if (run_sum > SUM_MAX) run_sum = SUM_MAX;
  endfunction

  // Decode one scan byte; at end of scan queue the image or the status word
  function automatic void decode_byte(input scan_byte_t b);
    logic [PIXEL_W-1:0] u;
    logic [PIXEL_W-1:0] p;
    status_e            st;
    image_word_t        w;
    u = b.sample + SAMPLE_OFFSET;
    if (comp_cnt < MAX_COMPRESSED_DEF) comp_cnt++;
    else comp_ovf = 1'b1;

    if (run_pending) begin
      run_pending = 1'b0;
      for (int i = 0; i < u; i++) store_pixel('0);
    end else if (u == 0) begin
      if (b.eos) store_pixel('0);
      else run_pending = 1'b1;
    end else begin
      store_pixel(u);
    end

    if (!b.eos) return;

    if (comp_ovf) st = STATUS_COMP_LONG;
    else if (dec_cnt == 0 && !dec_ovf) st = STATUS_EMPTY;
    else if (dec_ovf) st = STATUS_DEC_LONG;
    else if (dec_cnt < PIXELS) st = STATUS_SHORT;
    else st = STATUS_OK;

    if (st == STATUS_OK) begin
      for (int k = 0; k < WORDS; k++) begin
        w = '0;
        for (int j = 0; j < LANES; j++) begin
          if (k * LANES + j < PIXELS) begin
            p = pix_mem[k * LANES + j];
            if (p == run_peak) p = PEAK_MARK;
            w.pixel_word[j * PIXEL_W +: PIXEL_W] = p;
          end
        end
        w.word_index = k[INDEX_W-1:0];
        w.last_word  = (k == WORDS - 1);
        w.status     = STATUS_OK;
        w.total_sum  = run_sum[SUM_W-1:0];
        w.peak_value = run_peak;
        scan_out_q = {scan_out_q, w};
      end
    end else begin
      w = '0;
      w.last_word = 1'b1;
      w.status    = st;
      if (st != STATUS_COMP_LONG) begin
        w.total_sum  = run_sum[SUM_W-1:0];
        w.peak_value = run_peak;
      end
      scan_out_q = {scan_out_q, w};
    end
    clear_scan_state();
  endfunction

  // Offer one word, hold it until taken, then predict what it causes
  task automatic send_byte(input scan_byte_t b, input bit use_model);
    int unsigned gap;
    gap = source_steady ? 0 : idle_len(1'b1);
    if (gap > 0) begin
      scan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    scan_if.valid       <= 1'b1;
    scan_if.sample      <= b.sample;
    scan_if.end_of_scan <= b.eos;
    do @(posedge clk_i); while (!scan_if.ready);
    decode_byte(b);
    if (use_model) begin
      image_words_due = {image_words_due, scan_out_q};
    end
    scan_out_q.delete();
  endtask

  // Drop valid and hold until every predicted word has arrived
  task automatic wait_image_drained();
    scan_if.valid <= 1'b0;
    do @(posedge clk_i); while (image_words_due.size() != 0);
  endtask

  function automatic void push_scan_byte(input logic [SAMPLE_W-1:0] sample);
    scan_byte_t b;
    b.sample = sample;
    b.eos    = 1'b0;
    scan_bytes = {scan_bytes, b};
  endfunction

  // Build a scan of the given kind; runs dominate so most scans fill the image
  function automatic void build_scan(input scan_kind_e kind);
    int unsigned left;
    int unsigned c;
    int unsigned pick;
    scan_byte_t  b;
    bit          final_mark;
    scan_bytes.delete();
    final_mark = (kind == SCAN_FINAL_MARK);
    case (kind)
      SCAN_SHORT: left = $urandom_range(1, PIXELS - 1);
      SCAN_LONG:  left = $urandom_range(PIXELS + 1, PIXELS + 200);
      SCAN_EMPTY: left = 0;
      default:    left = final_mark ? PIXELS - 1 : PIXELS;
    endcase

    if (kind == SCAN_NOISE) begin
      repeat ($urandom_range(1, 24)) push_scan_byte(SAMPLE_W'($urandom()));
    end else if (kind == SCAN_EMPTY) begin
      repeat ($urandom_range(1, 3)) begin
        push_scan_byte(enc(0));
        push_scan_byte(enc(0));
      end
    end else begin
      while (left > 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          push_scan_byte(enc($urandom_range(1, 255)));
          left--;
        end else if (pick == 3) begin
          // run of no zeros
          push_scan_byte(enc(0));
          push_scan_byte(enc(0));
        end else begin
          c = $urandom_range(1, 255);
          if (c > left) c = left;
          push_scan_byte(enc(0));
          push_scan_byte(enc(c));
          left -= c;
        end
      end
      if (final_mark) push_scan_byte(enc(0));
      // lose one byte so marker and count fall out of step
      if (kind == SCAN_BROKEN && scan_bytes.size() > 1)
        scan_bytes.delete($urandom_range(0, scan_bytes.size() - 1));
    end

    b = scan_bytes.pop_back();
    b.eos = 1'b1;
    scan_bytes = {scan_bytes, b};
  endfunction

  task automatic send_scan();
    foreach (scan_bytes[i]) send_byte(scan_bytes[i], 1'b1);
  endtask

  // Flat scan of n plain pixel bytes, used for the compressed-length limit
  function automatic void build_flat_scan(input int unsigned n);
    scan_byte_t b;
    scan_bytes.delete();
    repeat (n) push_scan_byte(enc($urandom_range(1, 255)));
    b = scan_bytes.pop_back();
    b.eos = 1'b1;
    scan_bytes = {scan_bytes, b};
  endfunction

  // Receiver: random stalls, mostly short, with steady stretches
  initial begin
    int unsigned hold;
    hold = 0;
    image_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_steady) begin
        image_if.ready <= 1'b1;
      end else if (hold > 0) begin
        image_if.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        image_if.ready <= 1'b0;
        hold = idle_len(1'b0) - 1;
      end else begin
        image_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    image_word_t want;
    if (rst_ni && image_if.valid && image_if.ready) begin
      if (image_words_due.size() == 0) begin
        $error("unexpected word: word_index %0d status %0d", image_if.word_index,
               image_if.status);
        fail_count++;
      end else begin
        want = image_words_due.pop_front();
        if (image_if.pixel_word !== want.pixel_word) begin
          $error("pixel_word: expected %h, got %h", want.pixel_word, image_if.pixel_word);
          fail_count++;
        end
        if (image_if.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, image_if.word_index);
          fail_count++;
        end
        if (image_if.last_word !== want.last_word) begin
          $error("last_word: expected %0d, got %0d", want.last_word, image_if.last_word);
          fail_count++;
        end
        if (image_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, image_if.status);
          fail_count++;
        end
        if (image_if.total_sum !== want.total_sum) begin
          $error("total_sum: expected %0d, got %0d", want.total_sum, image_if.total_sum);
          fail_count++;
        end
        if (image_if.peak_value !== want.peak_value) begin
          $error("peak_value: expected %0d, got %0d", want.peak_value, image_if.peak_value);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on total run length
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("zero_rle_scan_to_image_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    image_word_t w;
    int unsigned rand_bytes;
    int unsigned rand_scans;
    int unsigned r;
    scan_kind_e  kind;

    scan_if.valid       = 1'b0;
    scan_if.sample      = '0;
    scan_if.end_of_scan = 1'b0;
    rst_ni              = 1'b0;
    clear_scan_state();

    // After reset: single bytes and the sample extremes
    add_row(stim(enc(128), 1'b1, 1'b1, STATUS_SHORT, 17'd128, 8'd128));
    add_row(stim(enc(255), 1'b1, 1'b1, STATUS_SHORT, 17'd255, 8'd255));
    add_row(stim(enc(127), 1'b1, 1'b1, STATUS_SHORT, 17'd127, 8'd127));
    // Marker as final byte gives one zero pixel
    add_row(stim(enc(0), 1'b1, 1'b1, STATUS_SHORT, 17'd0, 8'd0));
    // Run with a count of zero leaves the scan empty
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(0), 1'b1, 1'b1, STATUS_EMPTY, 17'd0, 8'd0));
    add_row(stim(enc(1), 1'b0));
    add_row(stim(enc(254), 1'b1));
    // Full image, peak pixel marked
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(255), 1'b0));
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(255), 1'b0));
    add_row(stim(enc(5), 1'b0));
    add_row(stim(enc(9), 1'b1));
    // Full image of zeros: every pixel equals the peak
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(255), 1'b0));
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(255), 1'b0));
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(2), 1'b1));
    // One pixel too many
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(255), 1'b0));
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(255), 1'b0));
    add_row(stim(enc(0), 1'b0));
    add_row(stim(enc(3), 1'b1, 1'b1, STATUS_DEC_LONG, 17'd0, 8'd0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, !dir_rows[i].typed);
      if (dir_rows[i].typed) begin
        w = '0;
        w.last_word  = 1'b1;
        w.status     = dir_rows[i].status;
        w.total_sum  = dir_rows[i].sum;
        w.peak_value = dir_rows[i].peak;
        image_words_due = {image_words_due, w};
      end
    end
    wait_image_drained();

    // Compressed length at the limit, then one byte past it
    build_flat_scan(MAX_COMPRESSED_DEF);
    send_scan();
    build_flat_scan(MAX_COMPRESSED_DEF + 1);
    send_scan();

    // Random scans, mostly well formed
    rand_bytes = 0;
    rand_scans = 0;
    while (rand_bytes < RAND_BYTES || rand_scans < RAND_SCANS) begin
      r = $urandom_range(0, 19);
      if (r < 9) kind = SCAN_EXACT;
      else if (r < 11) kind = SCAN_FINAL_MARK;
      else if (r < 13) kind = SCAN_SHORT;
      else if (r < 15) kind = SCAN_LONG;
      else if (r < 16) kind = SCAN_EMPTY;
      else if (r < 18) kind = SCAN_NOISE;
      else kind = SCAN_BROKEN;
      source_steady = ($urandom_range(0, 4) == 0);
      sink_steady   = ($urandom_range(0, 4) == 0);
      build_scan(kind);
      send_scan();
      rand_bytes += scan_bytes.size();
      rand_scans++;
      // hold the sender once until the image side is empty
      if (rand_scans == RAND_SCANS / 2) wait_image_drained();
    end

    wait_image_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("zero_rle_scan_to_image_tb: PASS");
    end else begin
      $display("zero_rle_scan_to_image_tb: FAIL");
    end
    $finish;
  end

endmodule
